// File: rtl/jagged_segment_permute_defines.svh
// Assertion macros for the segment permute block.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef JAGGED_SEGMENT_PERMUTE_DEFINES_SVH
`define JAGGED_SEGMENT_PERMUTE_DEFINES_SVH
`ifndef SYNTHESIS
`define JSP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define JSP_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define JSP_ASSERT(label, clk, rstn, prop, msg)
`define JSP_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

// File: rtl/jsp_pkg.sv
// Shared constants, types and codes for the segment permute block.
// No dependencies; imported by every module of the block.
package jsp_pkg;

    localparam int MAX_SEGMENTS    = 1024;
    localparam int MAX_VALUES      = 4096;
    localparam int MAX_SEG_ROWS    = 64;
    localparam int MAX_WEIGHT_COLS = 4;

    localparam int SEG_AW    = $clog2(MAX_SEGMENTS);
    localparam int SEG_CNT_W = SEG_AW + 1;
    localparam int ROW_AW    = $clog2(MAX_VALUES);
    localparam int VAL_CNT_W = ROW_AW + 1;
    localparam int OFF_W     = ROW_AW + 1;

    localparam int OP_W   = 2;
    localparam int LEN_W  = 7;
    localparam int POS_W  = 12;
    localparam int SEL_W  = 10;
    localparam int WORD_W = 64;
    localparam int WCOL_W = 3;
    localparam int CFG_W  = 32;
    localparam int ADDR_W = 3;

    // input tdata layout
    localparam int IN_LEN_LSB = 0;
    localparam int IN_IDX_LSB = IN_LEN_LSB + LEN_W;
    localparam int IN_WA_LSB  = IN_IDX_LSB + WORD_W;
    localparam int IN_SEL_LSB = IN_WA_LSB + MAX_WEIGHT_COLS * WORD_W;
    localparam int IN_BITS    = IN_SEL_LSB + SEL_W;
    localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int S_TUSER_W  = OP_W;

    // output tdata layout
    localparam int OUT_BITS  = LEN_W + POS_W + WORD_W + MAX_WEIGHT_COLS * WORD_W;
    localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int M_TUSER_W = 2;
    localparam int HAS_ROW_BIT = 0;
    localparam int ERROR_BIT   = 1;

    localparam logic REG_WCOLS = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR    = 2'd0,
        OP_LOAD_LEN = 2'd1,
        OP_LOAD_ROW = 2'd2,
        OP_SELECT   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEG_CHK,
        ST_ROW_RD,
        ST_ROW_LD
    } state_t;

    typedef struct packed {
        logic [ROW_AW-1:0] start;
        logic [LEN_W-1:0]  len;
    } seg_entry_t;

    typedef struct packed {
        logic [MAX_WEIGHT_COLS-1:0][WORD_W-1:0] weight;
        logic [WORD_W-1:0]                      index;
    } row_data_t;

    typedef struct packed {
        logic [OFF_W-1:0] sum;
        logic             over;
    } alu_res_t;

endpackage

// File: rtl/jsp_alu.sv
// Shared offset adder with store-limit compare, time-shared by the sequencer.
// Depends on jsp_pkg.
module jsp_alu (
    input  logic [jsp_pkg::OFF_W-1:0] a,
    input  logic [jsp_pkg::LEN_W-1:0] b,
    output jsp_pkg::alu_res_t         res
);
    import jsp_pkg::*;

    assign res.sum  = a + OFF_W'(b);
    assign res.over = res.sum > OFF_W'(MAX_VALUES);

endmodule

// File: rtl/jsp_seg_table.sv
// Segment table memory: start row and length per loaded segment.
// Depends on jsp_pkg; one write and one registered read port.
module jsp_seg_table (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [jsp_pkg::SEG_AW-1:0] waddr,
    input  jsp_pkg::seg_entry_t        wdata,
    input  logic                       re,
    input  logic [jsp_pkg::SEG_AW-1:0] raddr,
    output jsp_pkg::seg_entry_t        rdata
);
    import jsp_pkg::*;

    seg_entry_t mem [MAX_SEGMENTS];
    seg_entry_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // hold read data until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/jsp_row_store.sv
// Value row store: index word and all weight columns of each loaded row.
// Depends on jsp_pkg; one write and one registered read port per memory.
module jsp_row_store (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [jsp_pkg::ROW_AW-1:0] waddr,
    input  jsp_pkg::row_data_t         wdata,
    input  logic                       re,
    input  logic [jsp_pkg::ROW_AW-1:0] raddr,
    output jsp_pkg::row_data_t         rdata
);
    import jsp_pkg::*;

    logic [WORD_W-1:0]                      index_mem  [MAX_VALUES];
    logic [MAX_WEIGHT_COLS-1:0][WORD_W-1:0] weight_mem [MAX_VALUES];
    row_data_t                              rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            index_mem[waddr]  <= wdata.index;
            weight_mem[waddr] <= wdata.weight;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg.index  <= index_mem[raddr];
            rdata_reg.weight <= weight_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/jagged_segment_permute.sv
// Jagged segment permute: clear, load and load-row transfers are taken in the idle state.
// A select reads the segment entry, then checks it; an empty or error result is loaded
// from the check state, and otherwise each row takes a store read and an output load.
// Either output load waits while the result stream is stalled, and no input is taken.
// The shared offset adder serves load checks, select checks and row addressing.
// Reset (aresetn low, synchronous) clears counts, offset, overflow and the column count.
`include "jagged_segment_permute_defines.svh"
module jagged_segment_permute (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [jsp_pkg::ADDR_W-1:0]    paddr,
    input  logic [jsp_pkg::CFG_W-1:0]     pwdata,
    output logic [jsp_pkg::CFG_W-1:0]     prdata,
    output logic                          pready,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // seg_length, index_value, weight_a, weight_b, weight_c, weight_d, seg_select
    input  logic [jsp_pkg::S_TDATA_W-1:0] s_tdata,
    // op
    input  logic [jsp_pkg::S_TUSER_W-1:0] s_tuser,
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_length, out_position, out_index, out_weight_a .. out_weight_d
    output logic [jsp_pkg::M_TDATA_W-1:0] m_tdata,
    // has_row, error_flag
    output logic [jsp_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                          m_tlast
);
    import jsp_pkg::*;

    state_t                state_reg, state_next;
    logic [SEG_CNT_W-1:0]  seg_count_reg, seg_count_next;
    logic [VAL_CNT_W-1:0]  value_count_reg, value_count_next;
    logic [OFF_W-1:0]      last_end_reg, last_end_next;
    logic [OFF_W-1:0]      offset_reg, offset_next;
    logic                  overflow_reg, overflow_next;
    logic [WCOL_W-1:0]     wcols_reg;
    logic [SEL_W-1:0]      sel_reg, sel_next;
    logic [LEN_W-1:0]      row_cnt_reg, row_cnt_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic                  m_tvalid_reg;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [M_TUSER_W-1:0]  m_tuser_reg, m_tuser_next;
    logic                  m_tlast_reg, m_tlast_next;

    op_t                   in_op;
    logic [LEN_W-1:0]      in_len;
    logic [SEL_W-1:0]      in_sel;
    row_data_t             in_row;
    logic                  s_accept;
    logic                  out_free;
    logic                  out_load;
    logic                  cfg_write;
    logic [WCOL_W-1:0]     cols;

    logic [OFF_W-1:0]      alu_a;
    logic [LEN_W-1:0]      alu_b;
    alu_res_t              alu_res;

    logic                  seg_we, seg_re;
    seg_entry_t            seg_wdata, seg_rd;
    logic                  row_we, row_re;
    row_data_t             row_rd;

    logic                  sel_err;
    logic                  row_last;
    logic [MAX_WEIGHT_COLS-1:0][WORD_W-1:0] out_w;

    // ---------------- configuration ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wcols_reg <= '0;
        end else if (cfg_write && paddr[ADDR_W-1] == REG_WCOLS) begin
            wcols_reg <= pwdata[WCOL_W-1:0];
        end
    end

    assign prdata = (paddr[ADDR_W-1] == REG_WCOLS) ? CFG_W'(wcols_reg) : '0;

    assign cols = (wcols_reg > WCOL_W'(MAX_WEIGHT_COLS)) ? WCOL_W'(MAX_WEIGHT_COLS)
                                                          : wcols_reg;

    // ---------------- input unpacking ----------------
    assign in_op  = op_t'(s_tuser[OP_W-1:0]);
    assign in_len = s_tdata[IN_LEN_LSB +: LEN_W];
    assign in_sel = s_tdata[IN_SEL_LSB +: SEL_W];
    assign in_row.index  = s_tdata[IN_IDX_LSB +: WORD_W];
    assign in_row.weight = s_tdata[IN_WA_LSB +: MAX_WEIGHT_COLS * WORD_W];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // ---------------- shared adder and stores ----------------
    jsp_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    assign seg_wdata.start = last_end_reg[ROW_AW-1:0];
    assign seg_wdata.len   = in_len;

    jsp_seg_table u_seg_table (
        .aclk  (aclk),
        .we    (seg_we),
        .waddr (seg_count_reg[SEG_AW-1:0]),
        .wdata (seg_wdata),
        .re    (seg_re),
        .raddr (in_sel),
        .rdata (seg_rd)
    );

    jsp_row_store u_row_store (
        .aclk  (aclk),
        .we    (row_we),
        .waddr (value_count_reg[ROW_AW-1:0]),
        .wdata (in_row),
        .re    (row_re),
        .raddr (alu_res.sum[ROW_AW-1:0]),
        .rdata (row_rd)
    );

    // time-share the adder by sequencer step
    always_comb begin
        case (state_reg)
            ST_SEG_CHK: begin
                alu_a = offset_reg;
                alu_b = seg_rd.len;
            end
            ST_ROW_RD: begin
                alu_a = OFF_W'(seg_rd.start);
                alu_b = row_cnt_reg;
            end
            default: begin
                alu_a = last_end_reg;
                alu_b = in_len;
            end
        endcase
    end

    assign sel_err  = ({1'b0, sel_reg} >= seg_count_reg) || overflow_reg || alu_res.over;
    assign row_last = (row_cnt_reg == LEN_W'(seg_rd.len - LEN_W'(1)));

    always_comb begin
        for (int c = 0; c < MAX_WEIGHT_COLS; c++) begin
            out_w[c] = (WCOL_W'(c) < cols) ? row_rd.weight[c] : '0;
        end
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next       = state_reg;
        seg_count_next   = seg_count_reg;
        value_count_next = value_count_reg;
        last_end_next    = last_end_reg;
        offset_next      = offset_reg;
        overflow_next    = overflow_reg;
        sel_next         = sel_reg;
        row_cnt_next     = row_cnt_reg;
        pos_next         = pos_reg;
        seg_we           = 1'b0;
        seg_re           = 1'b0;
        row_we           = 1'b0;
        row_re           = 1'b0;
        out_load         = 1'b0;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        m_tlast_next     = m_tlast_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    case (in_op)
                        OP_CLEAR: begin
                            seg_count_next   = '0;
                            value_count_next = '0;
                            last_end_next    = '0;
                            offset_next      = '0;
                            overflow_next    = 1'b0;
                        end
                        OP_LOAD_LEN: begin
                            if (in_len > LEN_W'(MAX_SEG_ROWS) ||
                                seg_count_reg >= SEG_CNT_W'(MAX_SEGMENTS) ||
                                alu_res.over) begin
                                overflow_next = 1'b1;
                            end else begin
                                seg_we         = 1'b1;
                                last_end_next  = alu_res.sum;
                                seg_count_next = seg_count_reg + SEG_CNT_W'(1);
                            end
                        end
                        OP_LOAD_ROW: begin
                            if (value_count_reg >= VAL_CNT_W'(MAX_VALUES)) begin
                                overflow_next = 1'b1;
                            end else begin
                                row_we           = 1'b1;
                                value_count_next = value_count_reg + VAL_CNT_W'(1);
                            end
                        end
                        OP_SELECT: begin
                            seg_re     = 1'b1;
                            sel_next   = in_sel;
                            state_next = ST_SEG_CHK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SEG_CHK: begin
                if (sel_err || seg_rd.len == '0) begin
                    // single result without a row; hold until the output frees
                    if (out_free) begin
                        out_load     = 1'b1;
                        m_tdata_next = M_TDATA_W'({offset_reg[POS_W-1:0], LEN_W'(0)});
                        m_tuser_next = '0;
                        m_tuser_next[ERROR_BIT] = sel_err;
                        m_tlast_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    offset_next  = alu_res.sum;
                    pos_next     = offset_reg[POS_W-1:0];
                    row_cnt_next = '0;
                    state_next   = ST_ROW_RD;
                end
            end
            ST_ROW_RD: begin
                row_re     = 1'b1;
                state_next = ST_ROW_LD;
            end
            ST_ROW_LD: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    m_tdata_next = M_TDATA_W'({out_w, row_rd.index, pos_reg, seg_rd.len});
                    m_tuser_next = '0;
                    m_tuser_next[HAS_ROW_BIT] = 1'b1;
                    m_tlast_next = row_last;
                    row_cnt_next = row_cnt_reg + LEN_W'(1);
                    pos_next     = pos_reg + POS_W'(1);
                    state_next   = row_last ? ST_IDLE : ST_ROW_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            seg_count_reg   <= '0;
            value_count_reg <= '0;
            last_end_reg    <= '0;
            offset_reg      <= '0;
            overflow_reg    <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            seg_count_reg   <= seg_count_next;
            value_count_reg <= value_count_next;
            last_end_reg    <= last_end_next;
            offset_reg      <= offset_next;
            overflow_reg    <= overflow_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        sel_reg     <= sel_next;
        row_cnt_reg <= row_cnt_next;
        pos_reg     <= pos_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // ---------------- checks ----------------
    `JSP_ASSERT(a_empty_is_last, aclk, aresetn, m_tvalid && !m_tuser[HAS_ROW_BIT] |-> m_tlast, "empty or error result without last mark")
    `JSP_ASSERT(a_error_no_row, aclk, aresetn, m_tvalid && m_tuser[ERROR_BIT] |-> !m_tuser[HAS_ROW_BIT], "error result carries a row")
    `JSP_ASSERT(a_row_in_range, aclk, aresetn, state_reg == ST_ROW_RD |-> row_cnt_reg < seg_rd.len, "row counter past segment length")
    `JSP_ASSERT_NR(a_reset_drains, aclk, !aresetn |=> !m_tvalid && s_tready, "reset left output valid or input blocked")

endmodule

// File: tb/sv/jagged_segment_permute_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for jagged_segment_permute: streams clear, load and select
// transfers, predicts every result row and compares it field by field.
// Depends on rtl/jsp_pkg.sv and the block's RTL; needs nothing else.
module jagged_segment_permute_tb;
    import jsp_pkg::*;

    localparam int OUT_POS_LSB   = LEN_W;
    localparam int OUT_IDX_LSB   = OUT_POS_LSB + POS_W;
    localparam int OUT_WA_LSB    = OUT_IDX_LSB + WORD_W;
    localparam int SETTLE_CYCLES = 2 + 2 * MAX_SEG_ROWS + 24;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int MAX_PRINTED   = 40;
    localparam logic [ADDR_W-1:0] WCOL_ADDR = ADDR_W'(4 * REG_WCOLS);

    typedef struct packed {
        op_t                                    op;
        logic [LEN_W-1:0]                       len;
        logic [WORD_W-1:0]                      idx;
        logic [MAX_WEIGHT_COLS-1:0][WORD_W-1:0] w;
        logic [SEL_W-1:0]                       sel;
    } seg_item_t;

    typedef struct packed {
        logic [LEN_W-1:0]                       len;
        logic [POS_W-1:0]                       pos;
        logic                                   has_row;
        logic [WORD_W-1:0]                      idx;
        logic [MAX_WEIGHT_COLS-1:0][WORD_W-1:0] w;
        logic                                   last;
        logic                                   err;
    } row_result_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [ADDR_W-1:0]    paddr    = '0;
    logic [CFG_W-1:0]     pwdata   = '0;
    logic [CFG_W-1:0]     prdata;
    logic                 pready;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // seg_length, index_value, weight_a .. weight_d, seg_select
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // op
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // out_length, out_position, out_index, out_weight_a .. out_weight_d
    logic [M_TDATA_W-1:0] m_tdata;
    // has_row, error_flag
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    jagged_segment_permute uut (.*);

    always #4 aclk = ~aclk;

    // Predicted block state
    int                                     seg_start_tab [MAX_SEGMENTS];
    logic [LEN_W-1:0]                       seg_len_tab   [MAX_SEGMENTS];
    logic [WORD_W-1:0]                      index_mem     [MAX_VALUES];
    logic [MAX_WEIGHT_COLS-1:0][WORD_W-1:0] weight_mem    [MAX_VALUES];
    int          seg_count   = 0;
    int          row_count   = 0;
    int          out_offset  = 0;
    bit          overflow    = 1'b0;
    int          weight_cols = 0;
    row_result_t expected_rows [$];

    // Stimulus plan: what the generator knows of segments and written rows
    int        plan_seg_end [MAX_SEGMENTS];
    int        plan_seg_cnt      = 0;
    int        plan_row_cnt      = 0;
    int        plan_rows_written = 0;
    seg_item_t pending_items [$];
    seg_item_t held_item;
    int        items_queued = 0;
    int        items_taken  = 0;
    bit        in_taken     = 1'b0;
    int        cfg_writes   = 0;
    int        in_idle_pct  = 24;
    int        out_idle_pct = 24;
    int        mismatches   = 0;
    int        cycle_count  = 0;

    task automatic report_mismatch(string msg);
        if (mismatches < MAX_PRINTED)
            $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic permute_step(seg_item_t it);
        int          start;
        int          len;
        int          cols;
        row_result_t r;
        case (it.op)
            OP_CLEAR: begin
                seg_count  = 0;
                row_count  = 0;
                out_offset = 0;
                overflow   = 1'b0;
            end
            OP_LOAD_LEN: begin
                start = (seg_count > 0) ?
                        seg_start_tab[seg_count-1] + int'(seg_len_tab[seg_count-1]) : 0;
                if (it.len > MAX_SEG_ROWS || seg_count >= MAX_SEGMENTS ||
                    start + int'(it.len) > MAX_VALUES) begin
                    overflow = 1'b1;
                end else begin
                    seg_start_tab[seg_count] = start;
                    seg_len_tab[seg_count]   = it.len;
                    seg_count++;
                end
            end
            OP_LOAD_ROW: begin
                if (row_count >= MAX_VALUES) begin
                    overflow = 1'b1;
                end else begin
                    index_mem[row_count]  = it.idx;
                    weight_mem[row_count] = it.w;
                    row_count++;
                end
            end
            OP_SELECT: begin
                r      = '0;
                r.pos  = POS_W'(out_offset);
                r.last = 1'b1;
                if (int'(it.sel) >= seg_count || overflow ||
                    out_offset + int'(seg_len_tab[it.sel]) > MAX_VALUES) begin
                    r.err = 1'b1;
                    expected_rows.push_back(r);
                end else if (seg_len_tab[it.sel] == 0) begin
                    expected_rows.push_back(r);
                end else begin
                    len   = int'(seg_len_tab[it.sel]);
                    start = seg_start_tab[it.sel];
                    cols  = (weight_cols > MAX_WEIGHT_COLS) ? MAX_WEIGHT_COLS : weight_cols;
                    for (int i = 0; i < len; i++) begin
                        r.len     = LEN_W'(len);
                        r.pos     = POS_W'(out_offset + i);
                        r.has_row = 1'b1;
                        r.idx     = index_mem[(start + i) % MAX_VALUES];
                        for (int c = 0; c < MAX_WEIGHT_COLS; c++)
                            r.w[c] = (c < cols) ? weight_mem[(start + i) % MAX_VALUES][c] : '0;
                        r.last    = (i == len - 1);
                        expected_rows.push_back(r);
                    end
                    out_offset += len;
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_result();
        row_result_t want;
        if (expected_rows.size() == 0) begin
            report_mismatch("result transfer with nothing expected");
            return;
        end
        want = expected_rows.pop_front();
        if (m_tdata[LEN_W-1:0] !== want.len)
            report_mismatch($sformatf("pos %0d out_length got %0d want %0d",
                                      want.pos, m_tdata[LEN_W-1:0], want.len));
        if (m_tdata[OUT_POS_LSB +: POS_W] !== want.pos)
            report_mismatch($sformatf("out_position got %0d want %0d",
                                      m_tdata[OUT_POS_LSB +: POS_W], want.pos));
        if (m_tdata[OUT_IDX_LSB +: WORD_W] !== want.idx)
            report_mismatch($sformatf("pos %0d out_index got %h want %h",
                                      want.pos, m_tdata[OUT_IDX_LSB +: WORD_W], want.idx));
        for (int c = 0; c < MAX_WEIGHT_COLS; c++)
            if (m_tdata[OUT_WA_LSB + c * WORD_W +: WORD_W] !== want.w[c])
                report_mismatch($sformatf("pos %0d weight column %0d got %h want %h", want.pos,
                                          c, m_tdata[OUT_WA_LSB + c * WORD_W +: WORD_W],
                                          want.w[c]));
        if (m_tuser[HAS_ROW_BIT] !== want.has_row)
            report_mismatch($sformatf("pos %0d has_row got %b want %b",
                                      want.pos, m_tuser[HAS_ROW_BIT], want.has_row));
        if (m_tuser[ERROR_BIT] !== want.err)
            report_mismatch($sformatf("pos %0d error_flag got %b want %b",
                                      want.pos, m_tuser[ERROR_BIT], want.err));
        if (m_tlast !== want.last)
            report_mismatch($sformatf("pos %0d last_row got %b want %b",
                                      want.pos, m_tlast, want.last));
    endtask

    // pattern: 0 random data, 1 all zeros, 2 all ones; len and sel of -1 stay random
    task automatic add_item(op_t op, int len, int sel, int pattern = 0);
        seg_item_t it;
        int        start;
        it.op  = op;
        it.len = LEN_W'($urandom);
        it.idx = {$urandom, $urandom};
        for (int c = 0; c < MAX_WEIGHT_COLS; c++)
            it.w[c] = {$urandom, $urandom};
        it.sel = SEL_W'($urandom);
        if (len >= 0)
            it.len = LEN_W'(len);
        if (sel >= 0)
            it.sel = SEL_W'(sel);
        if (pattern == 1) begin
            it.idx = '0;
            it.w   = '0;
        end else if (pattern == 2) begin
            it.idx = '1;
            it.w   = '1;
        end
        // drop a select that would read rows never written since reset
        if (op == OP_SELECT && int'(it.sel) < plan_seg_cnt &&
            plan_seg_end[it.sel] > plan_rows_written)
            return;
        case (op)
            OP_CLEAR: begin
                plan_seg_cnt = 0;
                plan_row_cnt = 0;
            end
            OP_LOAD_LEN: begin
                start = (plan_seg_cnt > 0) ? plan_seg_end[plan_seg_cnt-1] : 0;
                if (it.len <= MAX_SEG_ROWS && plan_seg_cnt < MAX_SEGMENTS &&
                    start + int'(it.len) <= MAX_VALUES) begin
                    plan_seg_end[plan_seg_cnt] = start + int'(it.len);
                    plan_seg_cnt++;
                end
            end
            OP_LOAD_ROW: begin
                if (plan_row_cnt < MAX_VALUES) begin
                    plan_row_cnt++;
                    if (plan_row_cnt > plan_rows_written)
                        plan_rows_written = plan_row_cnt;
                end
            end
            default: ;
        endcase
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic add_batch();
        int first;
        int nrows;
        int len;
        if ($urandom_range(2) == 0)
            add_item(OP_CLEAR, -1, -1);
        first = plan_seg_cnt;
        nrows = 0;
        repeat ($urandom_range(1, 5)) begin
            case ($urandom_range(19))
                0:       len = $urandom_range(MAX_SEG_ROWS + 1, 127);
                1, 2:    len = $urandom_range(0, MAX_SEG_ROWS);
                default: len = $urandom_range(0, 5);
            endcase
            add_item(OP_LOAD_LEN, len, -1);
            if (len <= MAX_SEG_ROWS)
                nrows += len;
        end
        // sometimes load fewer rows, leaving stale rows from before a clear in play
        if ($urandom_range(4) == 0)
            nrows = $urandom_range(0, nrows);
        repeat (nrows)
            add_item(OP_LOAD_ROW, -1, -1);
        repeat ($urandom_range(1, 4)) begin
            if ($urandom_range(5) == 0 || plan_seg_cnt == 0)
                add_item(OP_SELECT, -1, -1);
            else
                add_item(OP_SELECT, -1,
                         $urandom_range((first < plan_seg_cnt) ? first : 0, plan_seg_cnt - 1));
        end
        if ($urandom_range(9) == 0)
            add_item(op_t'($urandom_range(3)), -1, -1);
    endtask

    task automatic drain_and_settle();
        while (items_taken != items_queued || expected_rows.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        @(posedge aclk);
    endtask

    task automatic set_wcols(int n);
        int seen;
        seen = cfg_writes;
        @(negedge aclk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= WCOL_ADDR;
        pwdata  <= CFG_W'(n);
        @(negedge aclk);
        penable <= 1'b1;
        while (cfg_writes == seen)
            @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Input driver and result-side stall
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_taken) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
                held_item = pending_items.pop_front();
                s_tdata  <= S_TDATA_W'({held_item.sel, held_item.w, held_item.idx,
                                        held_item.len});
                s_tuser  <= held_item.op;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(99) >= out_idle_pct);
    end

    // Monitor: check results, predict on each accepted transfer, track register writes
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                check_result();
            if (s_tvalid && s_tready) begin
                permute_step(held_item);
                items_taken++;
            end
            if (psel && penable && pwrite && pready) begin
                if (paddr == WCOL_ADDR)
                    weight_cols = int'(pwdata[WCOL_W-1:0]);
                cfg_writes++;
            end
        end
        in_taken <= aresetn && s_tvalid && s_tready;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int wcol_plan [4];
        int target;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every op, field extremes, empty and refused selects
        set_wcols(MAX_WEIGHT_COLS);
        add_item(OP_SELECT, -1, 0);
        add_item(OP_LOAD_LEN, 3, -1);
        add_item(OP_LOAD_LEN, 0, -1);
        add_item(OP_LOAD_LEN, 2, -1);
        add_item(OP_LOAD_ROW, -1, -1, 1);
        add_item(OP_LOAD_ROW, -1, -1, 2);
        repeat (3) add_item(OP_LOAD_ROW, -1, -1);
        add_item(OP_SELECT, -1, 0);
        add_item(OP_SELECT, -1, 1);
        add_item(OP_SELECT, -1, 2);
        add_item(OP_SELECT, -1, 2);
        add_item(OP_SELECT, -1, 3);
        add_item(OP_SELECT, -1, MAX_SEGMENTS - 1);
        add_item(OP_LOAD_LEN, 127, -1);
        add_item(OP_SELECT, -1, 0);
        add_item(OP_CLEAR, -1, -1);
        add_item(OP_SELECT, -1, 0);
        drain_and_settle();

        // Random batches under several column settings; the second runs with no idling
        wcol_plan    = '{1, 7, 2, 0};
        wcol_plan[3] = $urandom_range(0, 7);
        target       = items_queued;
        foreach (wcol_plan[p]) begin
            in_idle_pct  = (p == 1) ? 0 : 24;
            out_idle_pct = (p == 1) ? 0 : 24;
            set_wcols(wcol_plan[p]);
            target += 40;
            while (items_queued < target)
                add_batch();
            drain_and_settle();
        end

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// File: jagged_segment_permute.f
+incdir+rtl
rtl/jsp_pkg.sv
rtl/jsp_alu.sv
rtl/jsp_seg_table.sv
rtl/jsp_row_store.sv
rtl/jagged_segment_permute.sv
tb/sv/jagged_segment_permute_tb.sv
